// ----- design/som_pkg.sv -----
// shared types, constants and helpers for the series offset merge block
`default_nettype none

package som_pkg;

	// field widths
	localparam int VAL_W   = 16;
	localparam int WGT_W   = 24;
	localparam int NW_W    = 17;
	localparam int MINY_W  = 8;
	localparam int YRS_W   = 9;
	localparam int SUM_W   = 32;
	localparam int CNT_W   = 13;

	// overlap count limit
	localparam int MAX_MONTHS = 4096;
	localparam int COUNT_CAP  = (MAX_MONTHS < 8191) ? MAX_MONTHS : 8191;
	localparam logic [CNT_W-1:0] CNT_CAP_V = CNT_W'(COUNT_CAP);

	// months to years by reciprocal multiply, exact for counts below 8192
	localparam int RECIP_W    = 12;
	localparam int YEAR_SHIFT = 15;
	localparam logic [RECIP_W-1:0] YEAR_RECIP = RECIP_W'(2731);
	localparam int YRS_FULL_W = CNT_W + RECIP_W - YEAR_SHIFT;

	// datapath widths
	localparam int CORR_W = VAL_W + 1;
	localparam int MA_W   = WGT_W + 1;
	localparam int PROD_W = MA_W + CORR_W;
	localparam int WSUM_W = WGT_W + 1;
	localparam int QDIV_W = VAL_W;
	localparam int NUM_W  = WSUM_W + QDIV_W;
	localparam int QCNT_W = $clog2(QDIV_W);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_WEIGHT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEARS  = CFG_IDX_W'(1);
	localparam logic [NW_W-1:0] NEW_WEIGHT_RST = NW_W'(65536);

	// command and result kind codes
	localparam logic CMD_MEASURE  = 1'b0;
	localparam logic CMD_MERGE    = 1'b1;
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_MONTH   = 1'b1;

	typedef struct packed {
		logic                    command;
		logic signed [VAL_W-1:0] merged_value;
		logic                    merged_valid;
		logic [WGT_W-1:0]        merged_weight;
		logic signed [VAL_W-1:0] new_value;
		logic                    new_valid;
		logic                    last_item;
	} in_item_t;

	typedef struct packed {
		logic                    result_kind;
		logic signed [VAL_W-1:0] out_value;
		logic                    out_valid;
		logic [WGT_W-1:0]        out_weight;
		logic signed [VAL_W-1:0] offset_diff;
		logic [YRS_W-1:0]        overlap_years;
		logic                    merge_enabled;
		logic                    last_out;
	} res_item_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] dividend;
		logic [WSUM_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [QDIV_W-1:0] quotient;
	} div_rsp_t;

	// clamp a one-bit-wider signed value to the value range
	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [CORR_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v[CORR_W-1] != v[CORR_W-2]) begin
			r = v[CORR_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/som_div.sv -----
// serial signed divider, one quotient bit per cycle, saturating quotient
`default_nettype none

module som_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire som_pkg::div_req_t req,
	output som_pkg::div_rsp_t      rsp
);
	import som_pkg::*;

	localparam logic [1:0] DV_IDLE  = 2'd0;
	localparam logic [1:0] DV_CHECK = 2'd1;
	localparam logic [1:0] DV_RUN   = 2'd2;
	localparam logic [1:0] DV_DONE  = 2'd3;

	logic [1:0]        st_q;
	logic              neg_q;
	logic              ovf_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dvs_q;
	logic [QDIV_W-1:0] quo_q;
	logic [QCNT_W-1:0] cnt_q;

	logic [NUM_W-1:0]  mag;
	logic              ge;

	// magnitude of the dividend
	assign mag = req.dividend[NUM_W-1] ? NUM_W'(-req.dividend) : NUM_W'(req.dividend);
	assign ge  = (rem_q >= dvs_q);

	// sequencer: overflow check then restoring steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DV_IDLE;
		end else begin
			case (st_q)
				DV_IDLE: begin
					if (req.start) begin
						st_q <= DV_CHECK;
					end
				end
				DV_CHECK: begin
					st_q <= ge ? DV_DONE : DV_RUN;
				end
				DV_RUN: begin
					if (cnt_q == '0) begin
						st_q <= DV_DONE;
					end
				end
				DV_DONE: begin
					st_q <= DV_IDLE;
				end
				default: begin
					st_q <= DV_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: begin
				rem_q <= mag;
				dvs_q <= {req.divisor, {QDIV_W{1'b0}}};
				neg_q <= req.dividend[NUM_W-1];
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			DV_CHECK: begin
				ovf_q <= ge;
				dvs_q <= dvs_q >> 1;
				cnt_q <= QCNT_W'(QDIV_W - 1);
			end
			DV_RUN: begin
				if (ge) begin
					rem_q <= rem_q - dvs_q;
				end
				quo_q <= {quo_q[QDIV_W-2:0], ge};
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q - QCNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// signed, saturated quotient
	always_comb begin
		rsp.done = (st_q == DV_DONE);
		if (neg_q) begin
			if (ovf_q || (quo_q > {1'b1, {(QDIV_W-1){1'b0}}})) begin
				rsp.quotient = {1'b1, {(QDIV_W-1){1'b0}}};
			end else begin
				rsp.quotient = -quo_q;
			end
		end else begin
			if (ovf_q || quo_q[QDIV_W-1]) begin
				rsp.quotient = {1'b0, {(QDIV_W-1){1'b1}}};
			end else begin
				rsp.quotient = quo_q;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/series_offset_merge.sv -----
// Merges a new monthly series into a weighted merged series in two passes.
// A measure summary with pairs passes the sum, divider wait and put states; a merge item
// that needs an average passes the merge, multiply, add, divider wait and put states; any
// other result goes from sum or merge to put. The next item is accepted once the result
// is loaded into the output register; a measure item with no result keeps the block idle.
// Reset clears the sums, the stored offset and enable, and restores config defaults.
`default_nettype none

module series_offset_merge (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire som_pkg::in_item_t               in_data,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output som_pkg::res_item_t                   res_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [som_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [som_pkg::NW_W-1:0]        cfg_data
);
	import som_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_MRG  = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_WAIT = 3'd5;
	localparam logic [2:0] ST_PUT  = 3'd6;

	logic [2:0]              st_q;
	in_item_t                item_q;
	res_item_t               res_q;
	res_item_t               out_q;
	logic                    out_vld_q;
	logic signed [SUM_W-1:0] diff_sum_q;
	logic [CNT_W-1:0]        pc_q;
	logic signed [VAL_W-1:0] offset_q;
	logic                    allowed_q;
	logic [NW_W-1:0]         nw_q;
	logic [MINY_W-1:0]       miny_q;
	logic signed [NUM_W-1:0] acc_q;
	logic signed [NUM_W-1:0] prod_q;
	logic [WSUM_W-1:0]       wsum_q;

	logic                          in_acc;
	logic                          pair_ok;
	logic signed [SUM_W-1:0]       diff;
	logic signed [CORR_W-1:0]      corr;
	logic signed [MA_W-1:0]        mul_a;
	logic signed [CORR_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]      product;
	logic [CNT_W+RECIP_W-1:0]      yrs_prod;
	logic [YRS_FULL_W-1:0]         years_full;
	logic [YRS_W-1:0]              years_sat;
	logic                          en;
	logic [WSUM_W-1:0]             wsum;
	logic                          put_go;
	div_req_t                      dreq;
	div_rsp_t                      drsp;

	assign in_ready  = (st_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = out_vld_q;
	assign res_data  = out_q;
	assign put_go    = (st_q == ST_PUT) && (!out_vld_q || res_ready);

	// measure pass difference
	assign pair_ok = in_data.merged_valid && in_data.new_valid && (pc_q < CNT_CAP_V);
	assign diff = {{(SUM_W-VAL_W){in_data.new_value[VAL_W-1]}}, in_data.new_value}
		- {{(SUM_W-VAL_W){in_data.merged_value[VAL_W-1]}}, in_data.merged_value};

	// offset-corrected new value
	assign corr = {item_q.new_value[VAL_W-1], item_q.new_value}
		- {offset_q[VAL_W-1], offset_q};

	// overlap years and enable
	assign yrs_prod   = {{RECIP_W{1'b0}}, pc_q} * {{CNT_W{1'b0}}, YEAR_RECIP};
	assign years_full = yrs_prod[CNT_W+RECIP_W-1:YEAR_SHIFT];
	assign years_sat  = (years_full > YRS_FULL_W'({YRS_W{1'b1}})) ? {YRS_W{1'b1}}
		: years_full[YRS_W-1:0];
	assign en = (years_full >= YRS_FULL_W'(miny_q));

	assign wsum = {1'b0, item_q.merged_weight} + WSUM_W'(nw_q);

	// shared multiplier: merged weight times merged value, then new weight times corrected value
	always_comb begin
		if (st_q == ST_MUL2) begin
			mul_a = MA_W'(nw_q);
			mul_b = corr;
		end else begin
			mul_a = {1'b0, item_q.merged_weight};
			mul_b = {item_q.merged_value[VAL_W-1], item_q.merged_value};
		end
		product = mul_a * mul_b;
	end

	// divider request
	always_comb begin
		dreq.start = ((st_q == ST_SUM) && (pc_q != '0)) || (st_q == ST_ADD);
		if (st_q == ST_SUM) begin
			dreq.dividend = {{(NUM_W-SUM_W){diff_sum_q[SUM_W-1]}}, diff_sum_q};
			dreq.divisor  = WSUM_W'(pc_q);
		end else begin
			dreq.dividend = acc_q + prod_q;
			dreq.divisor  = wsum_q;
		end
	end

	som_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			out_vld_q  <= 1'b0;
			diff_sum_q <= '0;
			pc_q       <= '0;
			offset_q   <= '0;
			allowed_q  <= 1'b0;
			nw_q       <= NEW_WEIGHT_RST;
			miny_q     <= '0;
		end else begin
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NEW_WEIGHT: nw_q   <= cfg_data;
					CFG_MIN_YEARS:  miny_q <= cfg_data[MINY_W-1:0];
					default: begin
					end
				endcase
			end

			// output register handoff
			if (put_go) begin
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.command == CMD_MERGE) begin
							st_q <= ST_MRG;
						end else begin
							if (pair_ok) begin
								diff_sum_q <= diff_sum_q + diff;
								pc_q       <= pc_q + CNT_W'(1);
							end
							if (in_data.last_item) begin
								st_q <= ST_SUM;
							end
						end
					end
				end
				ST_SUM: begin
					diff_sum_q <= '0;
					pc_q       <= '0;
					if (pc_q == '0) begin
						offset_q  <= '0;
						allowed_q <= 1'b0;
						st_q      <= ST_PUT;
					end else begin
						allowed_q <= en;
						st_q      <= ST_WAIT;
					end
				end
				ST_MRG: begin
					if (item_q.new_valid && allowed_q && item_q.merged_valid && (wsum != '0)) begin
						st_q <= ST_MUL2;
					end else begin
						st_q <= ST_PUT;
					end
				end
				ST_MUL2: begin
					st_q <= ST_ADD;
				end
				ST_ADD: begin
					st_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (drsp.done) begin
						if (item_q.command == CMD_MEASURE) begin
							offset_q <= drsp.quotient;
						end
						st_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (put_go) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item, result and datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		if (put_go) begin
			out_q <= res_q;
		end
		case (st_q)
			ST_SUM: begin
				res_q.result_kind   <= KIND_SUMMARY;
				res_q.out_value     <= '0;
				res_q.out_valid     <= 1'b0;
				res_q.out_weight    <= '0;
				res_q.offset_diff   <= '0;
				res_q.last_out      <= 1'b1;
				res_q.overlap_years <= (pc_q == '0) ? '0 : years_sat;
				res_q.merge_enabled <= (pc_q == '0) ? 1'b0 : en;
			end
			ST_MRG: begin
				res_q.result_kind   <= KIND_MONTH;
				res_q.offset_diff   <= offset_q;
				res_q.overlap_years <= '0;
				res_q.merge_enabled <= allowed_q;
				res_q.last_out      <= item_q.last_item;
				acc_q               <= product[NUM_W-1:0];
				wsum_q              <= wsum;
				// missing new month or merging disabled passes the entry through
				if (!(item_q.new_valid && allowed_q)) begin
					res_q.out_value  <= item_q.merged_value;
					res_q.out_valid  <= item_q.merged_valid;
					res_q.out_weight <= item_q.merged_weight;
				end else if (!item_q.merged_valid) begin
					res_q.out_value  <= sat_val(corr);
					res_q.out_valid  <= 1'b1;
					res_q.out_weight <= WGT_W'(nw_q);
				end else begin
					res_q.out_value  <= item_q.merged_value;
					res_q.out_valid  <= 1'b1;
					res_q.out_weight <= wsum[WSUM_W-1] ? {WGT_W{1'b1}} : wsum[WGT_W-1:0];
				end
			end
			ST_MUL2: begin
				prod_q <= product[NUM_W-1:0];
			end
			ST_WAIT: begin
				if (drsp.done) begin
					if (item_q.command == CMD_MEASURE) begin
						res_q.offset_diff <= drsp.quotient;
					end else begin
						res_q.out_value <= drsp.quotient;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- verif/tb_series_offset_merge.sv -----
// testbench for series_offset_merge: offset measure and weighted merge checked against a predictor
`default_nettype none

module tb_series_offset_merge;
	timeunit 1ns;
	timeprecision 1ps;

	import som_pkg::*;

	localparam int     SETTLE_CYCLES = 40;
	localparam int     HOLD_CYCLES   = 300;
	localparam longint LIMIT_NS      = 10_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 res_valid;
	logic                 res_ready;
	res_item_t            res_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NW_W-1:0]      cfg_data;

	// predicted block state and register copies
	int acc_diff_sum    = 0;
	int acc_pairs       = 0;
	int cur_offset      = 0;
	bit cur_enabled     = 1'b0;
	int cur_new_weight  = 65536;
	int cur_min_years   = 0;

	// expected results in order, written at exp_tail and read at exp_head
	res_item_t expected_results[int];
	int        exp_head       = 0;
	int        exp_tail       = 0;
	int        mismatch_count = 0;
	bit        quiet          = 1'b0;
	bit        hold_request   = 1'b0;

	series_offset_merge dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	function automatic longint clamp_value(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// expected result of one accepted transaction, queued when there is one
	function automatic void predict_merge_result(in_item_t it);
		res_item_t r;
		longint    mv;
		longint    nv;
		longint    corr;
		longint    wsum;
		longint    num;
		int        years;
		bit        en;
		mv = it.merged_value;
		nv = it.new_value;
		r  = '0;
		if (it.command == CMD_MEASURE) begin
			if (it.merged_valid && it.new_valid && acc_pairs < COUNT_CAP) begin
				acc_diff_sum += int'(nv - mv);
				acc_pairs++;
			end
			if (!it.last_item) return;
			if (acc_pairs == 0) begin
				cur_offset = 0;
				years      = 0;
				en         = 1'b0;
			end else begin
				cur_offset = int'(clamp_value(longint'(acc_diff_sum) / acc_pairs));
				years      = acc_pairs / 12;
				en         = (years >= cur_min_years);
			end
			cur_enabled   = en;
			acc_diff_sum  = 0;
			acc_pairs     = 0;
			r.result_kind   = KIND_SUMMARY;
			r.offset_diff   = VAL_W'(cur_offset);
			r.overlap_years = YRS_W'((years > 511) ? 511 : years);
			r.merge_enabled = en;
			r.last_out      = 1'b1;
		end else begin
			r.result_kind = KIND_MONTH;
			r.out_value   = it.merged_value;
			r.out_valid   = it.merged_valid;
			r.out_weight  = it.merged_weight;
			if (it.new_valid && cur_enabled) begin
				corr = nv - cur_offset;
				if (!it.merged_valid) begin
					r.out_value  = VAL_W'(clamp_value(corr));
					r.out_weight = WGT_W'(cur_new_weight);
				end else begin
					wsum = longint'(it.merged_weight) + cur_new_weight;
					if (wsum != 0) begin
						num = longint'(it.merged_weight) * mv + longint'(cur_new_weight) * corr;
						r.out_value = VAL_W'(clamp_value(num / wsum));
					end
					r.out_weight = (wsum > 64'hFFFFFF) ? '1 : WGT_W'(wsum);
				end
				r.out_valid = 1'b1;
			end
			r.offset_diff   = VAL_W'(cur_offset);
			r.overlap_years = '0;
			r.merge_enabled = cur_enabled;
			r.last_out      = it.last_item;
		end
		expected_results[exp_tail] = r;
		exp_tail++;
	endfunction

	function automatic void check_field(string fname, longint want, longint got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 60)
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
		end
	endfunction

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (exp_tail == exp_head) begin
				mismatch_count++;
				if (mismatch_count <= 60)
					$display("%0t: unexpected result, expected none actual %h", $time, res_data);
			end else begin
				want = expected_results[exp_head];
				expected_results.delete(exp_head);
				exp_head++;
				check_field("result_kind", want.result_kind, res_data.result_kind);
				check_field("out_value", want.out_value, res_data.out_value);
				check_field("out_valid", want.out_valid, res_data.out_valid);
				check_field("out_weight", want.out_weight, res_data.out_weight);
				check_field("offset_diff", want.offset_diff, res_data.offset_diff);
				check_field("overlap_years", want.overlap_years, res_data.overlap_years);
				check_field("merge_enabled", want.merge_enabled, res_data.merge_enabled);
				check_field("last_out", want.last_out, res_data.last_out);
			end
		end
	end

	// result side: random stall bursts and one long hold-off on request
	initial begin : result_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		res_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return VAL_W'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return VAL_W'($urandom_range(0, 4000)) - 16'sd2000;
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] rand_weight();
		case ($urandom_range(0, 4))
			0: return WGT_W'($urandom);
			1: return '1;
			2: return '0;
			default: return WGT_W'($urandom_range(1, 64) << 16);
		endcase
	endfunction

	function automatic in_item_t make_month(logic cmd, logic last, int valid_pct);
		in_item_t it;
		it.command       = cmd;
		it.merged_value  = rand_value();
		it.merged_valid  = ($urandom_range(1, 100) <= valid_pct);
		it.merged_weight = rand_weight();
		it.new_value     = rand_value();
		it.new_valid     = ($urandom_range(1, 100) <= valid_pct);
		it.last_item     = last;
		return it;
	endfunction

	function automatic in_item_t item(logic cmd, int mv, logic mvalid, int mw, int nv,
			logic nvalid, logic last);
		in_item_t it;
		it.command       = cmd;
		it.merged_value  = VAL_W'(mv);
		it.merged_valid  = mvalid;
		it.merged_weight = WGT_W'(mw);
		it.new_value     = VAL_W'(nv);
		it.new_valid     = nvalid;
		it.last_item     = last;
		return it;
	endfunction

	// optional idle burst on the input side
	task automatic input_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9) - 1) @(negedge clk);
		end
	endtask

	// offer one input transaction and wait for its acceptance
	task automatic send_item(in_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		predict_merge_result(it);
		input_gap();
	endtask

	task automatic send_measure_pass(int n_months, int valid_pct);
		for (int i = 0; i < n_months; i++)
			send_item(make_month(CMD_MEASURE, i == n_months - 1, valid_pct));
	endtask

	task automatic send_merge_pass(int n_months);
		for (int i = 0; i < n_months; i++)
			send_item(make_month(CMD_MERGE, i == n_months - 1, 70));
	endtask

	// stop offering input, let every expected result arrive, then settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (exp_tail != exp_head) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= NW_W'(value);
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_NEW_WEIGHT)
			cur_new_weight = value & 32'h1FFFF;
		else if (idx == CFG_MIN_YEARS)
			cur_min_years = value & 32'hFF;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// field extremes, saturation, empty overlap and disabled merge at reset settings
	task automatic test_directed();
		send_item(item(CMD_MERGE, 100, 1, 24'h123456, 200, 1, 0));
		send_item(item(CMD_MEASURE, 5, 0, 0, 7, 1, 0));
		send_item(item(CMD_MEASURE, 5, 1, 0, 7, 0, 1));
		send_item(item(CMD_MERGE, -50, 1, 65536, 300, 1, 0));
		send_item(item(CMD_MERGE, 0, 0, 0, 300, 1, 1));
		send_item(item(CMD_MEASURE, -32768, 1, 0, 32767, 1, 1));
		send_item(item(CMD_MERGE, 1234, 1, 777, 4321, 0, 0));
		send_item(item(CMD_MERGE, 0, 0, 0, -32768, 1, 0));
		send_item(item(CMD_MERGE, 32767, 1, 24'hFFFFFF, 32767, 1, 1));
		send_item(item(CMD_MEASURE, 32767, 1, 0, -32768, 1, 1));
		send_item(item(CMD_MERGE, 0, 0, 0, 32767, 1, 0));
		send_item(item(CMD_MERGE, -32768, 1, 0, 0, 1, 1));
		// mean of -1, -1, 0 truncates toward zero
		send_item(item(CMD_MEASURE, 100, 1, 0, 99, 1, 0));
		send_item(item(CMD_MEASURE, 100, 1, 0, 99, 1, 0));
		send_item(item(CMD_MEASURE, 100, 1, 0, 100, 1, 1));
		send_item(item(CMD_MERGE, -3, 1, 65536, 0, 1, 0));
		send_item(item(CMD_MERGE, 3, 1, 65536, 0, 1, 1));
	endtask

	// new weight zero: summed weight zero keeps the merged value
	task automatic test_zero_new_weight();
		write_reg(CFG_NEW_WEIGHT, 0);
		write_reg(CFG_MIN_YEARS, 0);
		send_item(item(CMD_MEASURE, 0, 1, 0, 256, 1, 1));
		send_item(item(CMD_MERGE, 500, 1, 0, 100, 1, 0));
		send_item(item(CMD_MERGE, 0, 0, 0, -100, 1, 0));
		send_item(item(CMD_MERGE, -700, 1, 5, 300, 1, 1));
		drain_results();
	endtask

	// long overlap pass with many years, below the largest minimum years
	task automatic test_long_overlap();
		write_reg(CFG_NEW_WEIGHT, 65536);
		write_reg(CFG_MIN_YEARS, 255);
		send_measure_pass(400, 100);
		send_merge_pass(4);
		drain_results();
	endtask

	// result side holds off while input keeps coming
	task automatic test_backpressure();
		write_reg(CFG_MIN_YEARS, 0);
		send_measure_pass(30, 95);
		hold_request = 1'b1;
		send_merge_pass(40);
		drain_results();
	endtask

	// well-formed measure and merge passes with some noise transactions
	task automatic test_random_traffic(int new_weight, int min_data, int n_items);
		in_item_t   it;
		logic [63:0] raw;
		int          sent;
		int          len;
		write_reg(CFG_NEW_WEIGHT, new_weight);
		write_reg(CFG_MIN_YEARS, min_data);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				raw = {$urandom, $urandom};
				it  = raw[$bits(in_item_t)-1:0];
				send_item(it);
				sent++;
			end else begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 15);
				send_measure_pass(len, ($urandom_range(0, 4) == 0) ? 20 : 90);
				sent += len;
				len = $urandom_range(1, 20);
				send_merge_pass(len);
				sent += len;
			end
		end
		drain_results();
	endtask

	// test sequence
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_zero_new_weight();
		test_long_overlap();
		test_backpressure();
		test_random_traffic(65536, 17'h1FF01, 200);
		test_random_traffic(1, 0, 200);
		test_random_traffic($urandom_range(0, 65536), $urandom_range(0, 3), 200);
		test_random_traffic(65535, 2, 200);
		quiet = 1'b1;
		test_random_traffic(32768, 0, 200);

		drain_results();
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
